// File: design/spi_adc_channel_scan_master_defines.svh
// ----------------------------------------------------------------------------
// spi adc scan master assertion macros
// shared property shorthands, clocked on clk with rst_n as the disable
// ----------------------------------------------------------------------------
`ifndef SPI_ADC_CHANNEL_SCAN_MASTER_DEFINES_SVH
`define SPI_ADC_CHANNEL_SCAN_MASTER_DEFINES_SVH

// same-cycle implication
`define SPIADC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPIADC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/spiadc_pkg.sv
// ----------------------------------------------------------------------------
// spiadc_pkg
// shared constants, types and helpers of the spi adc scan master
// ----------------------------------------------------------------------------
package spiadc_pkg;

    localparam int FRAME_BITS  = 16;
    localparam int SAMPLE_BITS = 12;
    localparam int BC_W        = $clog2(FRAME_BITS);

    localparam int WORD_W = 16;
    localparam int SLOT_W = 8;
    localparam int IDX_W  = 3;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_INIT_WORD  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CMD_FIRST  = 3'd1;
    localparam logic [IDX_W-1:0] REG_CMD_SECOND = 3'd2;
    localparam logic [IDX_W-1:0] REG_CMD_THIRD  = 3'd3;
    localparam logic [IDX_W-1:0] REG_HOLD_SLOTS = 3'd4;
    localparam logic [IDX_W-1:0] REG_GAP_SLOTS  = 3'd5;

    // reset values of the registers
    localparam logic [WORD_W-1:0] RST_INIT_WORD  = 16'h1880;
    localparam logic [WORD_W-1:0] RST_CMD_FIRST  = 16'h1080;
    localparam logic [WORD_W-1:0] RST_CMD_SECOND = 16'h1100;
    localparam logic [WORD_W-1:0] RST_CMD_THIRD  = 16'h1180;
    localparam logic [SLOT_W-1:0] RST_HOLD_SLOTS = 8'd4;
    localparam logic [SLOT_W-1:0] RST_GAP_SLOTS  = 8'd4;

    // request codes
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_INIT  = 2'd1;
    localparam logic [1:0] REQ_SCAN1 = 2'd2;
    localparam logic [1:0] REQ_SCAN3 = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SHIFT = 2'd1,
        PH_HOLD  = 2'd2,
        PH_GAP   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] init_word;
        logic [WORD_W-1:0] cmd_word_first;
        logic [WORD_W-1:0] cmd_word_second;
        logic [WORD_W-1:0] cmd_word_third;
        logic [SLOT_W-1:0] hold_slots;
        logic [SLOT_W-1:0] gap_slots;
    } cfg_t;

    typedef struct packed {
        logic                   cs_n;
        logic                   mosi_bit;
        logic                   clock_pulse;
        logic                   sample_valid;
        logic [SAMPLE_BITS-1:0] sample_value;
        logic [1:0]             sample_index;
        logic                   last_sample;
        logic                   busy_res;
        logic                   req_dropped;
    } result_t;

    // frames sent for a request code
    function automatic logic [2:0] frames_in_mode(input logic [1:0] mode);
        logic [2:0] n;
        unique case (mode)
            REQ_INIT:  n = 3'd1;
            REQ_SCAN1: n = 3'd2;
            REQ_SCAN3: n = 3'd6;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    // command word for a frame pair of the given mode
    function automatic logic [WORD_W-1:0] word_for(input cfg_t cfg, input logic [1:0] mode,
                                                   input logic [1:0] pair);
        logic [WORD_W-1:0] w;
        w = cfg.cmd_word_first;
        if (mode == REQ_INIT)
        begin
            w = cfg.init_word;
        end
        else if (mode == REQ_SCAN3 && pair == 2'd0)
        begin
            w = cfg.cmd_word_second;
        end
        else if (mode == REQ_SCAN3 && pair == 2'd1)
        begin
            w = cfg.cmd_word_third;
        end
        return w;
    endfunction

    // fit a 16-bit word to the frame width
    function automatic logic [FRAME_BITS-1:0] frame_word(input logic [WORD_W-1:0] w);
        logic [FRAME_BITS+WORD_W-1:0] wide;
        wide = {{FRAME_BITS{1'b0}}, w};
        return wide[FRAME_BITS-1:0];
    endfunction

    // low sample bits of a read-back frame
    function automatic logic [SAMPLE_BITS-1:0] sample_of(input logic [FRAME_BITS-1:0] s);
        logic [FRAME_BITS+SAMPLE_BITS-1:0] wide;
        wide = {{SAMPLE_BITS{1'b0}}, s};
        return wide[SAMPLE_BITS-1:0];
    endfunction

endpackage

// File: design/spi_adc_channel_scan_master.sv
// ----------------------------------------------------------------------------
// spi_adc_channel_scan_master
// pin-level spi master scanning a serial adc, one bit slot per input word
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): one word per bit slot, carrying the
//   sampled miso bit and an optional request (init frame, one- or three-channel
//   scan); requests arriving mid-sequence are flagged in req_dropped and ignored
//   output channel (out_valid / out_stall): one word per input word with the
//   pins for that slot (cs_n, mosi_bit, clock_pulse) plus sample reports
//   a word accepted into the input register is worked on by the sequencer and
//   held in the output register, which drives the output channel
//   throughput: one word per cycle while the output does not stall, set by the
//   single-slot sequencer step
//   stall: the output register plus a skid entry keep the input side open as
//   the output stalls; a full skid entry raises in_stall until a word drains
//   reset: sequencer idle, configuration back to its defaults, both registers
//   empty; the user, unchecked by the block, has configuration written through
//   cfg_we / cfg_index / cfg_wdata only while no sequence or word is in flight
// ----------------------------------------------------------------------------
`include "spi_adc_channel_scan_master_defines.svh"

module spi_adc_channel_scan_master
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [spiadc_pkg::IDX_W-1:0]        cfg_index,
    input  logic [spiadc_pkg::WORD_W-1:0]       cfg_wdata,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic                                miso_bit,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                cs_n,
    output logic                                mosi_bit,
    output logic                                clock_pulse,
    output logic                                sample_valid,
    output logic [spiadc_pkg::SAMPLE_BITS-1:0]  sample_value,
    output logic [1:0]                          sample_index,
    output logic                                last_sample,
    output logic                                busy_res,
    output logic                                req_dropped
);
    import spiadc_pkg::*;

    // configuration registers
    cfg_t    cfg_reg;

    // input register
    logic       in_valid_reg;
    logic [1:0] req_reg;
    logic       miso_reg;

    logic    buf_full;
    logic    step;
    result_t step_word;
    result_t out_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_word       <= RST_INIT_WORD;
            cfg_reg.cmd_word_first  <= RST_CMD_FIRST;
            cfg_reg.cmd_word_second <= RST_CMD_SECOND;
            cfg_reg.cmd_word_third  <= RST_CMD_THIRD;
            cfg_reg.hold_slots      <= RST_HOLD_SLOTS;
            cfg_reg.gap_slots       <= RST_GAP_SLOTS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INIT_WORD:  cfg_reg.init_word       <= cfg_wdata;
                REG_CMD_FIRST:  cfg_reg.cmd_word_first  <= cfg_wdata;
                REG_CMD_SECOND: cfg_reg.cmd_word_second <= cfg_wdata;
                REG_CMD_THIRD:  cfg_reg.cmd_word_third  <= cfg_wdata;
                REG_HOLD_SLOTS: cfg_reg.hold_slots      <= cfg_wdata[SLOT_W-1:0];
                REG_GAP_SLOTS:  cfg_reg.gap_slots       <= cfg_wdata[SLOT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // the held word steps the sequencer whenever the output side has room
    assign step     = in_valid_reg && !buf_full;
    assign in_stall = in_valid_reg && buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            req_reg  <= req_type;
            miso_reg <= miso_bit;
        end
    end

    spiadc_engine u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .req_type (req_reg),
        .miso_bit (miso_reg),
        .cfg      (cfg_reg),
        .res      (step_word)
    );

    spiadc_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_word (step_word),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // output word onto the pins
    assign cs_n         = out_word.cs_n;
    assign mosi_bit     = out_word.mosi_bit;
    assign clock_pulse  = out_word.clock_pulse;
    assign sample_valid = out_word.sample_valid;
    assign sample_value = out_word.sample_value;
    assign sample_index = out_word.sample_index;
    assign last_sample  = out_word.last_sample;
    assign busy_res     = out_word.busy_res;
    assign req_dropped  = out_word.req_dropped;

    // a held word waits only while the buffer is full
    `SPIADC_ASSERT_NXT(a_held_word_kept, in_stall, in_valid_reg, "held input word dropped")
    `SPIADC_ASSERT_IMP(a_clock_needs_select, out_valid && clock_pulse, !cs_n && busy_res,
                       "clock pulse with chip select high")
    `SPIADC_ASSERT_IMP(a_idle_pins, out_valid && !busy_res,
                       cs_n && !mosi_bit && !clock_pulse && !sample_valid,
                       "pins active outside a sequence")

endmodule

// File: design/spiadc_engine.sv
// ----------------------------------------------------------------------------
// spiadc_engine
// frame sequencer: one bit slot per step, gives the pin word for that slot
// ----------------------------------------------------------------------------
`include "spi_adc_channel_scan_master_defines.svh"

module spiadc_engine
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [1:0]           req_type,
    input  logic                 miso_bit,
    input  spiadc_pkg::cfg_t     cfg,
    output spiadc_pkg::result_t  res
);
    import spiadc_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [1:0]            scan_mode_reg, scan_mode_next;
    logic [2:0]            frame_count_reg, frame_count_next;
    logic [BC_W-1:0]       bit_count_reg, bit_count_next;
    logic [SLOT_W-1:0]     slot_count_reg, slot_count_next;
    logic [FRAME_BITS-1:0] shift_out_reg, shift_out_next;
    logic [FRAME_BITS-1:0] shift_in_reg, shift_in_next;

    // state as seen in this slot, after a possible start
    logic                  start, dropped;
    phase_t                ph_e;
    logic [1:0]            mode_e;
    logic [2:0]            fc_e;
    logic [BC_W-1:0]       bc_e;
    logic [FRAME_BITS-1:0] so_e, si_e;

    logic                  last_bit;
    logic [FRAME_BITS-1:0] so_sh, si_sh;
    logic [3:0]            fc_inc;
    logic                  frames_done;
    logic [SLOT_W-1:0]     slot_dec;
    logic                  frame_end, hold_end, gap_end;
    logic                  to_hold, to_gap, to_next;

    always_comb
    begin
        start   = step && (req_type != REQ_NONE) && (phase_reg == PH_IDLE);
        dropped = step && (req_type != REQ_NONE) && (phase_reg != PH_IDLE);
        if (start)
        begin
            ph_e   = PH_SHIFT;
            mode_e = req_type;
            fc_e   = 3'd0;
            bc_e   = '0;
            so_e   = frame_word(word_for(cfg, req_type, 2'd0));
            si_e   = '0;
        end
        else
        begin
            ph_e   = phase_reg;
            mode_e = scan_mode_reg;
            fc_e   = frame_count_reg;
            bc_e   = bit_count_reg;
            so_e   = shift_out_reg;
            si_e   = shift_in_reg;
        end
    end

    assign last_bit    = (bc_e == BC_W'(FRAME_BITS - 1));
    assign so_sh       = {so_e[FRAME_BITS-2:0], 1'b0};
    assign si_sh       = {si_e[FRAME_BITS-2:0], miso_bit};
    assign fc_inc      = {1'b0, fc_e} + 4'd1;
    assign frames_done = (fc_inc >= {1'b0, frames_in_mode(mode_e)});
    assign slot_dec    = slot_count_reg - SLOT_W'(1);

    // end-of-phase decisions; zero hold or gap skips straight through
    assign frame_end = (ph_e == PH_SHIFT) && last_bit;
    assign hold_end  = (ph_e == PH_HOLD) && (slot_dec == '0);
    assign gap_end   = (ph_e == PH_GAP) && (slot_dec == '0);
    assign to_hold   = frame_end && (cfg.hold_slots != '0);
    assign to_gap    = ((frame_end && (cfg.hold_slots == '0)) || hold_end)
                       && (cfg.gap_slots != '0);
    assign to_next   = ((frame_end && (cfg.hold_slots == '0)) || hold_end)
                       && (cfg.gap_slots == '0) || gap_end;

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        scan_mode_next   = scan_mode_reg;
        frame_count_next = frame_count_reg;
        bit_count_next   = bit_count_reg;
        slot_count_next  = slot_count_reg;
        shift_out_next   = shift_out_reg;
        shift_in_next    = shift_in_reg;
        if (step)
        begin
            phase_next       = ph_e;
            scan_mode_next   = mode_e;
            frame_count_next = fc_e;
            bit_count_next   = bc_e;
            shift_out_next   = so_e;
            shift_in_next    = si_e;
            unique case (ph_e)
                PH_IDLE:
                begin
                end
                PH_SHIFT:
                begin
                    shift_out_next = so_sh;
                    shift_in_next  = si_sh;
                    bit_count_next = bc_e + BC_W'(1);
                end
                PH_HOLD, PH_GAP:
                begin
                    slot_count_next = slot_dec;
                end
                default:
                begin
                end
            endcase
            priority if (to_hold)
            begin
                phase_next      = PH_HOLD;
                slot_count_next = cfg.hold_slots;
            end
            else if (to_gap)
            begin
                phase_next      = PH_GAP;
                slot_count_next = cfg.gap_slots;
            end
            else if (to_next)
            begin
                if (frames_done)
                begin
                    phase_next       = PH_IDLE;
                    frame_count_next = 3'd0;
                    slot_count_next  = '0;
                end
                else
                begin
                    phase_next       = PH_SHIFT;
                    frame_count_next = fc_inc[2:0];
                    shift_out_next   = frame_word(word_for(cfg, mode_e, fc_inc[2:1]));
                    shift_in_next    = '0;
                    bit_count_next   = '0;
                end
            end
            else
            begin
            end
        end
    end

    // pin word for this slot
    always_comb
    begin
        res              = '0;
        res.cs_n         = 1'b1;
        res.req_dropped  = dropped;
        unique case (ph_e)
            PH_IDLE:
            begin
            end
            PH_SHIFT:
            begin
                res.busy_res    = 1'b1;
                res.cs_n        = 1'b0;
                res.clock_pulse = 1'b1;
                res.mosi_bit    = so_e[FRAME_BITS-1];
                if (last_bit && (mode_e >= REQ_SCAN1) && fc_e[0])
                begin
                    res.sample_valid = 1'b1;
                    res.sample_value = sample_of(si_sh);
                    res.sample_index = fc_e[2:1];
                    res.last_sample  = frames_done;
                end
            end
            PH_HOLD:
            begin
                res.busy_res = 1'b1;
                res.cs_n     = 1'b0;
            end
            PH_GAP:
            begin
                res.busy_res = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            scan_mode_reg   <= 2'd0;
            frame_count_reg <= 3'd0;
            bit_count_reg   <= '0;
            slot_count_reg  <= '0;
            shift_out_reg   <= '0;
            shift_in_reg    <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            scan_mode_reg   <= scan_mode_next;
            frame_count_reg <= frame_count_next;
            bit_count_reg   <= bit_count_next;
            slot_count_reg  <= slot_count_next;
            shift_out_reg   <= shift_out_next;
            shift_in_reg    <= shift_in_next;
        end
    end

    `SPIADC_ASSERT_IMP(a_frame_range, 1'b1, frame_count_reg < 3'd6, "frame count out of range")
    `SPIADC_ASSERT_IMP(a_idle_clear, phase_reg == PH_IDLE, frame_count_reg == 3'd0,
                       "frame count left set in idle")
    `SPIADC_ASSERT_IMP(a_sample_in_frame, step && res.sample_valid,
                       res.clock_pulse && !res.cs_n && res.busy_res,
                       "sample outside a clocked frame slot")

endmodule

// File: design/spiadc_outbuf.sv
// ----------------------------------------------------------------------------
// spiadc_outbuf
// result register with skid entry towards the output channel
// ----------------------------------------------------------------------------
`include "spi_adc_channel_scan_master_defines.svh"

module spiadc_outbuf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  spiadc_pkg::result_t  push_word,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output spiadc_pkg::result_t  out_word
);
    import spiadc_pkg::*;

    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = head_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_word  = head_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (!head_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_next       = push_word;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_word;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    `SPIADC_ASSERT_IMP(a_skid_behind_head, skid_valid_reg, head_valid_reg,
                       "skid entry held without a head word")
    `SPIADC_ASSERT_IMP(a_no_push_full, push, !skid_valid_reg, "word pushed into a full buffer")
    `SPIADC_ASSERT_NXT(a_skid_kept, skid_valid_reg && !pop, skid_valid_reg,
                       "skid word lost while stalled")

endmodule

// File: tb/sv/spi_adc_slot_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi adc scan master slot checker
// follows register writes and accepted input words, predicts the pins and
// sample report of every bit slot and compares them with the output words
// ----------------------------------------------------------------------------
module spi_adc_slot_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [spiadc_pkg::IDX_W-1:0]        cfg_index,
    input  logic [spiadc_pkg::WORD_W-1:0]       cfg_wdata,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic                                miso_bit,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                cs_n,
    input  logic                                mosi_bit,
    input  logic                                clock_pulse,
    input  logic                                sample_valid,
    input  logic [spiadc_pkg::SAMPLE_BITS-1:0]  sample_value,
    input  logic [1:0]                          sample_index,
    input  logic                                last_sample,
    input  logic                                busy_res,
    input  logic                                req_dropped,
    output int                                  fail_count,
    output int                                  pending,
    output logic                                seq_active
);
    import spiadc_pkg::*;

    cfg_t                   regs_now;
    phase_t                 seq_phase;
    logic [1:0]             seq_mode;
    logic [2:0]             frame_no;
    int                     bits_done;
    logic [SLOT_W-1:0]      slots_left;
    logic [FRAME_BITS-1:0]  tx_shift;
    logic [FRAME_BITS-1:0]  rx_shift;
    result_t                expected_slots[$];
    int                     mismatch_reports;

    function automatic int frames_for(input logic [1:0] mode);
        int n;
        case (mode)
            REQ_INIT:  n = 1;
            REQ_SCAN1: n = 2;
            REQ_SCAN3: n = 6;
            default:   n = 0;
        endcase
        return n;
    endfunction

    function automatic string slot_text(input result_t r);
        return {$sformatf("cs_n=%0b mosi=%0b clk=%0b sv=%0b ",
                          r.cs_n, r.mosi_bit, r.clock_pulse, r.sample_valid),
                $sformatf("val=%03h idx=%0d last=%0b busy=%0b drop=%0b",
                          r.sample_value, r.sample_index, r.last_sample, r.busy_res,
                          r.req_dropped)};
    endfunction

    // pick the command word of the current frame and start shifting it
    task automatic load_next_word();
        logic [WORD_W-1:0] w;
        w = regs_now.cmd_word_first;
        if (seq_mode == REQ_INIT)
        begin
            w = regs_now.init_word;
        end
        else if (seq_mode == REQ_SCAN3 && frame_no[2:1] == 2'd0)
        begin
            w = regs_now.cmd_word_second;
        end
        else if (seq_mode == REQ_SCAN3 && frame_no[2:1] == 2'd1)
        begin
            w = regs_now.cmd_word_third;
        end
        tx_shift  = FRAME_BITS'(w);
        rx_shift  = '0;
        bits_done = 0;
        seq_phase = PH_SHIFT;
    endtask

    task automatic close_frame();
        frame_no = frame_no + 3'd1;
        if (int'(frame_no) >= frames_for(seq_mode))
        begin
            seq_phase  = PH_IDLE;
            frame_no   = '0;
            slots_left = '0;
        end
        else
        begin
            load_next_word();
        end
    endtask

    task automatic open_gap();
        if (regs_now.gap_slots != '0)
        begin
            seq_phase  = PH_GAP;
            slots_left = regs_now.gap_slots;
        end
        else
        begin
            close_frame();
        end
    endtask

    task automatic predict_slot(input logic [1:0] rq, input logic mb, output result_t r);
        r      = '0;
        r.cs_n = 1'b1;
        if (rq != REQ_NONE)
        begin
            if (seq_phase == PH_IDLE)
            begin
                seq_mode = rq;
                frame_no = '0;
                load_next_word();
            end
            else
            begin
                r.req_dropped = 1'b1;
            end
        end
        case (seq_phase)
            PH_SHIFT:
            begin
                r.busy_res    = 1'b1;
                r.cs_n        = 1'b0;
                r.clock_pulse = 1'b1;
                r.mosi_bit    = tx_shift[FRAME_BITS-1];
                tx_shift      = tx_shift << 1;
                rx_shift      = {rx_shift[FRAME_BITS-2:0], mb};
                bits_done++;
                if (bits_done >= FRAME_BITS)
                begin
                    if (seq_mode >= REQ_SCAN1 && frame_no[0])
                    begin
                        r.sample_valid = 1'b1;
                        r.sample_value = rx_shift[SAMPLE_BITS-1:0];
                        r.sample_index = frame_no[2:1];
                        r.last_sample  = (int'(frame_no) + 1 >= frames_for(seq_mode));
                    end
                    if (regs_now.hold_slots != '0)
                    begin
                        seq_phase  = PH_HOLD;
                        slots_left = regs_now.hold_slots;
                    end
                    else
                    begin
                        open_gap();
                    end
                end
            end
            PH_HOLD:
            begin
                r.busy_res = 1'b1;
                r.cs_n     = 1'b0;
                slots_left = slots_left - 1'b1;
                if (slots_left == '0)
                begin
                    open_gap();
                end
            end
            PH_GAP:
            begin
                r.busy_res = 1'b1;
                slots_left = slots_left - 1'b1;
                if (slots_left == '0)
                begin
                    close_frame();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            regs_now.init_word       = RST_INIT_WORD;
            regs_now.cmd_word_first  = RST_CMD_FIRST;
            regs_now.cmd_word_second = RST_CMD_SECOND;
            regs_now.cmd_word_third  = RST_CMD_THIRD;
            regs_now.hold_slots      = RST_HOLD_SLOTS;
            regs_now.gap_slots       = RST_GAP_SLOTS;
            seq_phase        = PH_IDLE;
            seq_mode         = REQ_NONE;
            frame_no         = '0;
            bits_done        = 0;
            slots_left       = '0;
            tx_shift         = '0;
            rx_shift         = '0;
            fail_count       = 0;
            mismatch_reports = 0;
            expected_slots.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INIT_WORD:  regs_now.init_word       = cfg_wdata;
                    REG_CMD_FIRST:  regs_now.cmd_word_first  = cfg_wdata;
                    REG_CMD_SECOND: regs_now.cmd_word_second = cfg_wdata;
                    REG_CMD_THIRD:  regs_now.cmd_word_third  = cfg_wdata;
                    REG_HOLD_SLOTS: regs_now.hold_slots      = cfg_wdata[SLOT_W-1:0];
                    REG_GAP_SLOTS:  regs_now.gap_slots       = cfg_wdata[SLOT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                predict_slot(req_type, miso_bit, want);
                expected_slots.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = '{cs_n, mosi_bit, clock_pulse, sample_valid, sample_value,
                        sample_index, last_sample, busy_res, req_dropped};
                if (expected_slots.size() == 0)
                begin
                    fail_count++;
                    if (mismatch_reports < 10)
                    begin
                        mismatch_reports++;
                        $display("unexpected output word: %s", slot_text(got));
                    end
                end
                else
                begin
                    want = expected_slots.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (mismatch_reports < 10)
                        begin
                            mismatch_reports++;
                            $display("slot mismatch at %0t", $realtime);
                            $display("  expected %s", slot_text(want));
                            $display("  actual   %s", slot_text(got));
                        end
                    end
                end
            end
        end
        pending    = expected_slots.size();
        seq_active = (seq_phase != PH_IDLE);
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spi adc scan master testbench
// drives bit-slot words and register writes into the scan master, stalls the
// output side at random and leaves prediction and comparison to the checker
// ----------------------------------------------------------------------------
module tb;

    import spiadc_pkg::*;

    localparam int LONG_HOLD = 200;     // cycles of output back-pressure
    localparam int SETTLE    = 6;       // cycles after the last word drains

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [IDX_W-1:0]        cfg_index;
    logic [WORD_W-1:0]       cfg_wdata;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              req_type;
    logic                    miso_bit;
    logic                    out_valid;
    logic                    out_stall;
    logic                    cs_n;
    logic                    mosi_bit;
    logic                    clock_pulse;
    logic                    sample_valid;
    logic [SAMPLE_BITS-1:0]  sample_value;
    logic [1:0]              sample_index;
    logic                    last_sample;
    logic                    busy_res;
    logic                    req_dropped;

    int                      fail_count;
    int                      pending;
    logic                    seq_active;

    // idling switches, so that some stretches run flat out
    logic                    tx_idle_on;
    logic                    rx_idle_on;
    // asks the receiver for one long stall
    logic                    long_hold_req;

    spi_adc_channel_scan_master u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .miso_bit     (miso_bit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cs_n         (cs_n),
        .mosi_bit     (mosi_bit),
        .clock_pulse  (clock_pulse),
        .sample_valid (sample_valid),
        .sample_value (sample_value),
        .sample_index (sample_index),
        .last_sample  (last_sample),
        .busy_res     (busy_res),
        .req_dropped  (req_dropped)
    );

    spi_adc_slot_checker u_slot_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .miso_bit     (miso_bit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cs_n         (cs_n),
        .mosi_bit     (mosi_bit),
        .clock_pulse  (clock_pulse),
        .sample_valid (sample_valid),
        .sample_value (sample_value),
        .sample_index (sample_index),
        .last_sample  (last_sample),
        .busy_res     (busy_res),
        .req_dropped  (req_dropped),
        .fail_count   (fail_count),
        .pending      (pending),
        .seq_active   (seq_active)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #10_000_000;
        $display("** spi_adc_channel_scan_master: FAILED **");
        $finish;
    end

    // one bit-slot word; starts and ends at a falling edge
    task automatic send_slot(input logic [1:0] rq, input logic mb);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type = rq;
        miso_bit = mb;
        in_valid = 1'b1;
        // accepted at the first rising edge with stall low
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // feed empty slots until the running sequence has ended
    task automatic drain_sequence();
        while (seq_active)
        begin
            send_slot(REQ_NONE, 1'($urandom));
        end
    endtask

    // stop offering words and let every expected word come out
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // write every register, then an index past the list which must be ignored;
    // the slot registers get junk in the upper byte
    task automatic program_regs(input logic [WORD_W-1:0] iw, input logic [WORD_W-1:0] c1,
                                input logic [WORD_W-1:0] c2, input logic [WORD_W-1:0] c3,
                                input logic [SLOT_W-1:0] hold, input logic [SLOT_W-1:0] gap);
        cfg_we    = 1'b1;
        cfg_index = REG_INIT_WORD;
        cfg_wdata = iw;
        @(negedge clk);
        cfg_index = REG_CMD_FIRST;
        cfg_wdata = c1;
        @(negedge clk);
        cfg_index = REG_CMD_SECOND;
        cfg_wdata = c2;
        @(negedge clk);
        cfg_index = REG_CMD_THIRD;
        cfg_wdata = c3;
        @(negedge clk);
        cfg_index = REG_HOLD_SLOTS;
        cfg_wdata = {8'($urandom), hold};
        @(negedge clk);
        cfg_index = REG_GAP_SLOTS;
        cfg_wdata = {8'($urandom), gap};
        @(negedge clk);
        cfg_index = REG_GAP_SLOTS + IDX_W'(1 + $urandom_range(0, 1));
        cfg_wdata = 16'($urandom);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // mostly well-formed traffic: requests when idle, a few stray ones mid-sequence
    task automatic run_random(input int n_words);
        logic [1:0] rq;
        repeat (n_words)
        begin
            if (!seq_active)
            begin
                rq = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : REQ_NONE;
            end
            else
            begin
                rq = ($urandom_range(0, 24) == 0) ? 2'($urandom_range(1, 3)) : REQ_NONE;
            end
            send_slot(rq, 1'($urandom));
        end
        drain_sequence();
        settle();
    endtask

    // output side: random stall before each word if rx_idle_on, plus the one long hold
    initial
    begin
        int   stall_len;
        logic long_hold_done;
        out_stall      = 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                // keep the output blocked while the sender goes on offering
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1'b1;
            end
            stall_len = rx_idle_on ? $urandom_range(0, 8) : 0;
            if (stall_len > 0)
            begin
                out_stall = 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // stimulus
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_INIT_WORD;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        req_type      = REQ_NONE;
        miso_bit      = 1'b0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b0;
        long_hold_req = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // init frame at the reset settings, with a scan request that must be dropped
        send_slot(REQ_INIT, 1'b1);
        send_slot(REQ_SCAN3, 1'b0);
        drain_sequence();
        settle();

        // extreme words, no hold and no gap: frames run back to back
        program_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'd0, 8'd0);
        send_slot(REQ_SCAN1, 1'b1);
        repeat (15) send_slot(REQ_NONE, 1'b1);
        // lands on the first bit of the second frame, dropped
        send_slot(REQ_INIT, 1'b0);
        drain_sequence();
        // next request right after the sequence ends
        send_slot(REQ_SCAN3, 1'b0);
        send_slot(REQ_SCAN1, 1'b1);
        drain_sequence();
        settle();

        // random part
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 8'd0, 8'd0);
        run_random(60);

        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1, 8'd0);
        run_random(30);

        rx_idle_on = 1'b0;
        program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd1);
        run_random(30);

        // longest hold and gap, a single init frame, no idling at all
        tx_idle_on = 1'b0;
        program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     8'd255, 8'd255);
        send_slot(REQ_INIT, 1'($urandom));
        drain_sequence();
        settle();

        // short random hold and gap, with the long output hold in the middle
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
        run_random(20);
        long_hold_req = 1'b1;
        run_random(40);

        // back to the reset values
        program_regs(RST_INIT_WORD, RST_CMD_FIRST, RST_CMD_SECOND, RST_CMD_THIRD,
                     RST_HOLD_SLOTS, RST_GAP_SLOTS);
        run_random(40);

        settle();
        if (fail_count == 0 && pending == 0)
        begin
            $display("** spi_adc_channel_scan_master: PASSED **");
        end
        else
        begin
            $display("** spi_adc_channel_scan_master: FAILED **");
        end
        $finish;
    end

endmodule
